### src/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int OP_W         = 3;
    localparam int ID_W         = 16;
    localparam int KEY_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_FIND   = 3'd2,
        OP_POP    = 3'd3,
        OP_PEEK   = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_IDX    = 2'd0,
        RD_IDX_M1 = 2'd1,
        RD_IDX_P1 = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic    accept;
        logic    idx_zero;
        logic    idx_fill;
        logic    idx_inc;
        logic    idx_dec;
        rd_sel_t rd_sel;
        logic    wr_en;
        logic    wr_new;
        logic    fill_inc;
        logic    fill_dec;
        logic    fill_clear;
        logic    head_capture;
        logic    status_set;
        status_t status_code;
    } cmd_t;

    typedef struct packed {
        logic fill_zero;
        logic full;
        logic idx_zero;
        logic idx_at_fill;
        logic next_at_fill;
        logic key_less;
        logic id_match;
    } flags_t;

endpackage

### src/spq_datapath.sv
`timescale 1ns / 1ps
// Datapath: entry memory, index and fill registers, result registers.
module spq_datapath #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spq_pkg::cmd_t                 cmd,
    output spq_pkg::flags_t               flags,
    input  logic [spq_pkg::ID_W-1:0]      node_id,
    input  logic [spq_pkg::KEY_W-1:0]     cost_key,
    output logic [spq_pkg::STATUS_W-1:0]  status,
    output logic [spq_pkg::ID_W-1:0]      head_id,
    output logic [spq_pkg::KEY_W-1:0]     head_key,
    output logic [spq_pkg::COUNT_W-1:0]   entry_count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    spq_pkg::entry_t mem [CAPACITY];
    spq_pkg::entry_t rd_data_reg;

    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] idx_p1, idx_m1, rd_ptr;
    logic [spq_pkg::ID_W-1:0]     id_reg;
    logic [spq_pkg::KEY_W-1:0]    key_reg;
    logic [spq_pkg::STATUS_W-1:0] status_reg;
    logic [spq_pkg::ID_W-1:0]     head_id_reg;
    logic [spq_pkg::KEY_W-1:0]    head_key_reg;
    spq_pkg::entry_t wr_data;

    assign idx_p1 = idx_reg + CW'(1);
    assign idx_m1 = idx_reg - CW'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            spq_pkg::RD_IDX_M1: rd_ptr = idx_m1;
            spq_pkg::RD_IDX_P1: rd_ptr = idx_p1;
            default:            rd_ptr = idx_reg;
        endcase
    end

    always_comb
    begin
        if (cmd.wr_new)
        begin
            wr_data.id  = id_reg;
            wr_data.key = key_reg;
        end
        else
        begin
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[idx_reg[IW-1:0]] <= wr_data;
        end
        rd_data_reg <= mem[rd_ptr[IW-1:0]];
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_zero)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_fill)
        begin
            idx_next = fill_reg;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_p1;
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_m1;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.fill_clear)
        begin
            fill_next = '0;
        end
        else if (cmd.fill_inc)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (cmd.fill_dec)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            idx_reg  <= idx_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            id_reg       <= node_id;
            key_reg      <= cost_key;
            head_id_reg  <= '0;
            head_key_reg <= '0;
        end
        if (cmd.status_set)
        begin
            status_reg <= cmd.status_code;
        end
        else if (cmd.accept)
        begin
            status_reg <= spq_pkg::ST_OK;
        end
        if (cmd.head_capture)
        begin
            head_id_reg  <= rd_data_reg.id;
            head_key_reg <= rd_data_reg.key;
        end
    end

    assign flags.fill_zero    = (fill_reg == '0);
    assign flags.full         = (fill_reg == CW'(CAPACITY));
    assign flags.idx_zero     = (idx_reg == '0);
    assign flags.idx_at_fill  = (idx_reg == fill_reg);
    assign flags.next_at_fill = (idx_p1 >= fill_reg);
    assign flags.key_less     = (rd_data_reg.key < key_reg);
    assign flags.id_match     = (rd_data_reg.id == id_reg);

    assign status      = status_reg;
    assign head_id     = head_id_reg;
    assign head_key    = head_key_reg;
    assign entry_count = spq_pkg::COUNT_W'(fill_reg);

endmodule

### src/spq_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences search, shift and head access for each command.
module spq_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [spq_pkg::OP_W-1:0]  operation,
    input  spq_pkg::flags_t           flags,
    output spq_pkg::cmd_t             cmd,
    output logic                      busy,
    output logic                      done
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_INS_RD   = 10'b00_0000_0010,
        S_INS_WR   = 10'b00_0000_0100,
        S_SRCH_RD  = 10'b00_0000_1000,
        S_SRCH_CHK = 10'b00_0001_0000,
        S_SHF_RD   = 10'b00_0010_0000,
        S_SHF_WR   = 10'b00_0100_0000,
        S_HEAD_RD  = 10'b00_1000_0000,
        S_HEAD_CHK = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    spq_pkg::op_t op_reg, op_next;
    spq_pkg::op_t op_in;

    assign op_in = spq_pkg::op_t'(operation);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.rd_sel = spq_pkg::RD_IDX;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    op_next    = op_in;
                    state_next = S_DONE;
                    case (op_in)
                        spq_pkg::OP_INSERT:
                        begin
                            if (flags.full)
                            begin
                                cmd.status_set  = 1'b1;
                                cmd.status_code = spq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.idx_fill = 1'b1;
                                state_next   = S_INS_RD;
                            end
                        end
                        spq_pkg::OP_REMOVE, spq_pkg::OP_FIND:
                        begin
                            cmd.idx_zero = 1'b1;
                            state_next   = S_SRCH_RD;
                        end
                        spq_pkg::OP_POP, spq_pkg::OP_PEEK:
                        begin
                            if (flags.fill_zero)
                            begin
                                cmd.status_set  = 1'b1;
                                cmd.status_code = spq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.idx_zero = 1'b1;
                                state_next   = S_HEAD_RD;
                            end
                        end
                        spq_pkg::OP_CLEAR:
                        begin
                            cmd.fill_clear = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                if (flags.idx_zero)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_new   = 1'b1;
                    cmd.fill_inc = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = spq_pkg::RD_IDX_M1;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_en = 1'b1;
                if (flags.key_less)
                begin
                    cmd.wr_new   = 1'b1;
                    cmd.fill_inc = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_INS_RD;
                end
            end
            S_SRCH_RD:
            begin
                if (flags.idx_at_fill)
                begin
                    cmd.status_set  = 1'b1;
                    cmd.status_code = spq_pkg::ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK:
            begin
                if (flags.id_match)
                begin
                    state_next = (op_reg == spq_pkg::OP_REMOVE) ? S_SHF_RD : S_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SRCH_RD;
                end
            end
            S_SHF_RD:
            begin
                if (flags.next_at_fill)
                begin
                    cmd.fill_dec = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = spq_pkg::RD_IDX_P1;
                    state_next = S_SHF_WR;
                end
            end
            S_SHF_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_SHF_RD;
            end
            S_HEAD_RD:
            begin
                state_next = S_HEAD_CHK;
            end
            S_HEAD_CHK:
            begin
                cmd.head_capture = 1'b1;
                state_next = (op_reg == spq_pkg::OP_POP) ? S_SHF_RD : S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= spq_pkg::OP_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

### src/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Top level of the sorted priority queue.
//
// A word is taken when start is high and busy is low; busy then stays high
// until the result word has been shown. The result appears on status,
// head_id, head_key and entry_count for exactly one cycle with done high,
// and the receiver must take it then: there is no way to hold it off.
// Entries sit in one single-port memory of CAPACITY words with a registered
// read, so every search or shift step is a read followed by a compare or a
// write. Insert walks from the tail towards the head, moving each entry whose
// key is not less than the new key up one place, and writes the new entry into
// the gap; find and remove scan from the head for a matching id, and a remove
// that hits then moves every entry behind the match down one place; pop takes
// the head into head_id and head_key and then removes it the same way, peek
// only takes it; clear empties the queue; insert on a full queue and pop or
// peek on an empty one only set a status, and unused codes do nothing.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [spq_pkg::OP_W-1:0]      operation,
    input  logic [spq_pkg::ID_W-1:0]      node_id,
    input  logic [spq_pkg::KEY_W-1:0]     cost_key,
    output logic                          done,
    output logic [spq_pkg::STATUS_W-1:0]  status,
    output logic [spq_pkg::ID_W-1:0]      head_id,
    output logic [spq_pkg::KEY_W-1:0]     head_key,
    output logic [spq_pkg::COUNT_W-1:0]   entry_count
);

    spq_pkg::cmd_t   cmd;
    spq_pkg::flags_t flags;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .flags     (flags),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .flags       (flags),
        .node_id     (node_id),
        .cost_key    (cost_key),
        .status      (status),
        .head_id     (head_id),
        .head_key    (head_key),
        .entry_count (entry_count)
    );

endmodule
